// ===== sv/pme_pkg.sv =====
package pme_pkg;

  // Field and register widths
  localparam int CMD_W       = 3;
  localparam int NODE_W      = 6;
  localparam int COST_IN_W   = 16;
  localparam int PHER_W      = 32;
  localparam int COEF_W      = 17;
  localparam int NUM_NODES_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = PHER_W + COEF_W;

  // Parameter defaults
  localparam int MAX_NODES_DEF  = 64;
  localparam int COST_WIDTH_DEF = 16;

  // Register reset values and fixed-point constants
  localparam logic [NUM_NODES_W-1:0] NUM_NODES_RST = 7'd64;
  localparam logic [PHER_W-1:0]      MIN_PHER_RST  = 32'h0001_0000;
  localparam logic [COEF_W-1:0]      COEF_ONE      = 17'h1_0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PHER  = 1'b1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 3'd0,
    CMD_WRITE_COST = 3'd1,
    CMD_SET_PHER   = 3'd2,
    CMD_DEPOSIT    = 3'd3,
    CMD_EVAPORATE  = 3'd4,
    CMD_FILL       = 3'd5
  } pme_cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_DEP_A,
    S_DEP_B,
    S_EVAP,
    S_EVAP_D1,
    S_EVAP_D2,
    S_FILL
  } pme_state_t;

  // Input item
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [NODE_W-1:0]    src_node;
    logic [NODE_W-1:0]    dst_node;
    logic [COST_IN_W-1:0] cost_in;
    logic [PHER_W-1:0]    pher_value;
    logic [COEF_W-1:0]    evap_coef;
  } pme_in_t;

  // Result item
  typedef struct packed {
    logic [COST_IN_W-1:0] cost_out;
    logic [PHER_W-1:0]    pher_out;
    logic                 index_error;
  } pme_out_t;

  // Write enables toward the stores
  typedef struct packed {
    logic cost_we;
    logic pher_we;
  } pme_wen_t;

endpackage

// ===== sv/pheromone_matrix_engine_top.sv =====
// Write cost, set pheromone and rejected or unused commands end in S_EXEC; read
// adds S_RD, deposit S_DEP_A and S_DEP_B, fill a sweep of the store, evaporate
// a sweep, S_EVAP_D1 and S_EVAP_D2. Each store has one read and one write port.
// One item at a time; the next item is accepted in the cycle of the strobe.
// Results cannot be stalled. Synchronous reset clears the sequencer and config
// registers (num_nodes 64, min_pheromone 1.0); store contents are not cleared.
module pheromone_matrix_engine_top #(
  parameter int MAX_NODES  = pme_pkg::MAX_NODES_DEF,
  parameter int COST_WIDTH = pme_pkg::COST_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  pme_pkg::pme_in_t               in_data,
  output logic                           busy,
  output logic                           out_valid,
  output pme_pkg::pme_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [pme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pme_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pme_pkg::*;

  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [NUM_NODES_W-1:0] num_nodes_r;
  logic [PHER_W-1:0]      min_pher_r;

  pme_wen_t               wen;
  logic [ADDR_W-1:0]      cost_waddr, pher_waddr, raddr;
  logic [COST_WIDTH-1:0]  cost_wdata, cost_rdata;
  logic [PHER_W-1:0]      pher_wdata, pher_rdata;
  logic                   ev_in_vld, ev_out_vld;
  logic [ADDR_W-1:0]      ev_in_addr, ev_out_addr;
  logic [COEF_W-1:0]      ev_coef;
  logic [PHER_W-1:0]      ev_out_pher;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r <= NUM_NODES_RST;
      min_pher_r  <= MIN_PHER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_NODES: num_nodes_r <= cfg_wdata[NUM_NODES_W-1:0];
        REG_MIN_PHER:  min_pher_r  <= cfg_wdata[PHER_W-1:0];
        default:       num_nodes_r <= num_nodes_r;
      endcase
    end
  end

  pme_ctrl #(
    .MaxNodes (MAX_NODES),
    .CostW    (COST_WIDTH),
    .Depth    (DEPTH),
    .AddrW    (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_data     (in_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .num_nodes   (num_nodes_r),
    .min_pher    (min_pher_r),
    .wen         (wen),
    .cost_waddr  (cost_waddr),
    .cost_wdata  (cost_wdata),
    .pher_waddr  (pher_waddr),
    .pher_wdata  (pher_wdata),
    .raddr       (raddr),
    .cost_rdata  (cost_rdata),
    .pher_rdata  (pher_rdata),
    .ev_in_vld   (ev_in_vld),
    .ev_in_addr  (ev_in_addr),
    .ev_coef     (ev_coef),
    .ev_out_vld  (ev_out_vld),
    .ev_out_addr (ev_out_addr),
    .ev_out_pher (ev_out_pher)
  );

  pme_store #(
    .Depth (DEPTH),
    .AddrW (ADDR_W),
    .CostW (COST_WIDTH)
  ) u_store (
    .clk        (clk),
    .wen        (wen),
    .cost_waddr (cost_waddr),
    .cost_wdata (cost_wdata),
    .pher_waddr (pher_waddr),
    .pher_wdata (pher_wdata),
    .raddr      (raddr),
    .cost_rdata (cost_rdata),
    .pher_rdata (pher_rdata)
  );

  pme_evap #(
    .AddrW (ADDR_W)
  ) u_evap (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ev_in_vld),
    .in_addr  (ev_in_addr),
    .in_pher  (pher_rdata),
    .coef     (ev_coef),
    .min_pher (min_pher_r),
    .out_vld  (ev_out_vld),
    .out_addr (ev_out_addr),
    .out_pher (ev_out_pher)
  );

endmodule

// ===== sv/pme_store.sv =====
module pme_store #(
  parameter int Depth = 4096,
  parameter int AddrW = 12,
  parameter int CostW = 16
) (
  input  logic                       clk,
  input  pme_pkg::pme_wen_t          wen,
  input  logic [AddrW-1:0]           cost_waddr,
  input  logic [CostW-1:0]           cost_wdata,
  input  logic [AddrW-1:0]           pher_waddr,
  input  logic [pme_pkg::PHER_W-1:0] pher_wdata,
  input  logic [AddrW-1:0]           raddr,
  output logic [CostW-1:0]           cost_rdata,
  output logic [pme_pkg::PHER_W-1:0] pher_rdata
);
  import pme_pkg::*;

  logic [CostW-1:0]  cost_mem [Depth];
  logic [PHER_W-1:0] pher_mem [Depth];

  // Cost store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen.cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_rdata <= cost_mem[raddr];
  end

  // Pheromone store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen.pher_we) begin
      pher_mem[pher_waddr] <= pher_wdata;
    end
    pher_rdata <= pher_mem[raddr];
  end

endmodule

// ===== sv/pme_evap.sv =====
module pme_evap #(
  parameter int AddrW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [AddrW-1:0]           in_addr,
  input  logic [pme_pkg::PHER_W-1:0] in_pher,
  input  logic [pme_pkg::COEF_W-1:0] coef,
  input  logic [pme_pkg::PHER_W-1:0] min_pher,
  output logic                       out_vld,
  output logic [AddrW-1:0]           out_addr,
  output logic [pme_pkg::PHER_W-1:0] out_pher
);
  import pme_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic              vld_r;
  logic [AddrW-1:0]  addr_r;
  logic [PHER_W-1:0] scaled;

  // Multiply stage: entry times Q1.16 coefficient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    prod_r <= PROD_W'(in_pher) * PROD_W'(coef);
    addr_r <= in_addr;
  end

  // Truncate back to Q16.16 and apply the floor
  assign scaled   = prod_r[PHER_W+15:16];
  assign out_pher = (scaled > min_pher) ? scaled : min_pher;
  assign out_vld  = vld_r;
  assign out_addr = addr_r;

endmodule

// ===== sv/pme_ctrl.sv =====
module pme_ctrl #(
  parameter int MaxNodes = 64,
  parameter int CostW    = 16,
  parameter int Depth    = 4096,
  parameter int AddrW    = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  pme_pkg::pme_in_t                in_data,
  output logic                            busy,
  output logic                            out_valid,
  output pme_pkg::pme_out_t               out_data,
  input  logic [pme_pkg::NUM_NODES_W-1:0] num_nodes,
  input  logic [pme_pkg::PHER_W-1:0]      min_pher,
  output pme_pkg::pme_wen_t               wen,
  output logic [AddrW-1:0]                cost_waddr,
  output logic [CostW-1:0]                cost_wdata,
  output logic [AddrW-1:0]                pher_waddr,
  output logic [pme_pkg::PHER_W-1:0]      pher_wdata,
  output logic [AddrW-1:0]                raddr,
  input  logic [CostW-1:0]                cost_rdata,
  input  logic [pme_pkg::PHER_W-1:0]      pher_rdata,
  output logic                            ev_in_vld,
  output logic [AddrW-1:0]                ev_in_addr,
  output logic [pme_pkg::COEF_W-1:0]      ev_coef,
  input  logic                            ev_out_vld,
  input  logic [AddrW-1:0]                ev_out_addr,
  input  logic [pme_pkg::PHER_W-1:0]      ev_out_pher
);
  import pme_pkg::*;

  localparam int CNT_W = ($clog2(MaxNodes + 1) > NUM_NODES_W) ?
                         $clog2(MaxNodes + 1) : NUM_NODES_W;
  localparam logic [AddrW-1:0] LAST_ADDR = AddrW'(Depth - 1);

  function automatic logic [PHER_W-1:0] sat_add(input logic [PHER_W-1:0] a,
                                               input logic [PHER_W-1:0] b);
    logic [PHER_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PHER_W] ? {PHER_W{1'b1}} : sum[PHER_W-1:0];
  endfunction

  pme_state_t          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [AddrW-1:0]    a_r, b_r;
  logic                err_r;
  logic [COST_IN_W-1:0] cost_r;
  logic [PHER_W-1:0]   val_r;
  logic [COEF_W-1:0]   coef_r;
  logic [AddrW-1:0]    ptr_r;
  logic                ev_vld_r;
  logic [AddrW-1:0]    ev_addr_r;
  logic                out_valid_r;
  pme_out_t            out_r;

  logic                accept;
  logic [CNT_W-1:0]    n_eff;
  logic                pair_ok;
  logic                edge_cmd;
  logic                ptr_last;
  logic                res_set;
  pme_out_t            res;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign ptr_last = (ptr_r == LAST_ADDR);

  // Node pair check at accept time
  assign n_eff    = (CNT_W'(num_nodes) > CNT_W'(MaxNodes)) ? CNT_W'(MaxNodes)
                                                           : CNT_W'(num_nodes);
  assign pair_ok  = (in_data.src_node != in_data.dst_node) &&
                    (CNT_W'(in_data.src_node) < n_eff) &&
                    (CNT_W'(in_data.dst_node) < n_eff);
  assign edge_cmd = in_data.cmd inside {CMD_READ, CMD_WRITE_COST, CMD_SET_PHER, CMD_DEPOSIT};

  // Item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.cmd;
      err_r  <= edge_cmd && !pair_ok;
      a_r    <= AddrW'(32'(in_data.src_node) * 32'(MaxNodes) + 32'(in_data.dst_node));
      b_r    <= AddrW'(32'(in_data.dst_node) * 32'(MaxNodes) + 32'(in_data.src_node));
      cost_r <= in_data.cost_in;
      val_r  <= in_data.pher_value;
      coef_r <= (in_data.evap_coef > COEF_ONE) ? COEF_ONE : in_data.evap_coef;
    end
  end

  // State, sweep pointer and read-issue tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ev_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= (state_r == S_EVAP);
    end
    ev_addr_r <= ptr_r;
    if (accept) begin
      ptr_r <= '0;
    end else if (state_r == S_EVAP || state_r == S_FILL) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (err_r) begin
          state_nxt = S_IDLE;
        end else begin
          case (cmd_r)
            CMD_READ:      state_nxt = S_RD;
            CMD_DEPOSIT:   state_nxt = S_DEP_A;
            CMD_EVAPORATE: state_nxt = S_EVAP;
            CMD_FILL:      state_nxt = S_FILL;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:      state_nxt = S_IDLE;
      S_DEP_A:   state_nxt = S_DEP_B;
      S_DEP_B:   state_nxt = S_IDLE;
      S_EVAP: begin
        if (ptr_last) state_nxt = S_EVAP_D1;
      end
      S_EVAP_D1: state_nxt = S_EVAP_D2;
      S_EVAP_D2: state_nxt = S_IDLE;
      S_FILL: begin
        if (ptr_last) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Store accesses and result formation
  always_comb begin
    wen        = '0;
    cost_waddr = a_r;
    cost_wdata = CostW'(32'(cost_r));
    pher_waddr = a_r;
    pher_wdata = val_r;
    raddr      = a_r;
    res_set    = 1'b0;
    res        = '0;
    case (state_r)
      S_EXEC: begin
        if (err_r) begin
          res_set         = 1'b1;
          res.index_error = 1'b1;
        end else begin
          case (cmd_r)
            CMD_READ:      raddr = a_r;
            CMD_WRITE_COST: begin
              wen.cost_we = 1'b1;
              res_set     = 1'b1;
            end
            CMD_SET_PHER: begin
              wen.pher_we = 1'b1;
              pher_wdata  = (val_r > min_pher) ? val_r : min_pher;
              res_set     = 1'b1;
            end
            CMD_DEPOSIT:   raddr = a_r;
            CMD_EVAPORATE: raddr = ptr_r;
            CMD_FILL:      raddr = ptr_r;
            default:       res_set = 1'b1;
          endcase
        end
      end
      S_RD: begin
        res_set      = 1'b1;
        res.cost_out = COST_IN_W'(32'(cost_rdata));
        res.pher_out = pher_rdata;
      end
      S_DEP_A: begin
        wen.pher_we = 1'b1;
        pher_waddr  = a_r;
        pher_wdata  = sat_add(pher_rdata, val_r);
        raddr       = b_r;
      end
      S_DEP_B: begin
        wen.pher_we = 1'b1;
        pher_waddr  = b_r;
        pher_wdata  = sat_add(pher_rdata, val_r);
        res_set     = 1'b1;
      end
      S_EVAP:    raddr = ptr_r;
      S_EVAP_D1: raddr = ptr_r;
      S_EVAP_D2: res_set = 1'b1;
      S_FILL: begin
        wen.pher_we = 1'b1;
        pher_waddr  = ptr_r;
        pher_wdata  = min_pher;
        res_set     = ptr_last;
      end
      default: res_set = 1'b0;
    endcase
    // Write-back from the evaporation pipeline
    if (ev_out_vld) begin
      wen.pher_we = 1'b1;
      pher_waddr  = ev_out_addr;
      pher_wdata  = ev_out_pher;
    end
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_set;
    end
    if (res_set) begin
      out_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign ev_in_vld  = ev_vld_r;
  assign ev_in_addr = ev_addr_r;
  assign ev_coef    = coef_r;

endmodule

// ===== sv/pme_checker.sv =====
module pme_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input pme_pkg::pme_out_t out_data
);
  import pme_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Results come after the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // At most one result per item, never in two adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A rejected pair returns zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.index_error) |->
      (out_data.cost_out == '0 && out_data.pher_out == '0))
    else $error("index error with nonzero data");

endmodule

bind pheromone_matrix_engine_top pme_checker u_pme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pme_pkg::*;

  localparam int NODES = 64;
  localparam int DEPTH = NODES * NODES;
  localparam int DRAIN_LIMIT = 10000;

  // Command codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    pme_in_t  item;
    bit       typed;
    pme_out_t want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  pme_in_t               in_data   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  busy;
  logic                  out_valid;
  pme_out_t              out_data;

  pheromone_matrix_engine_top #(
    .MAX_NODES (NODES),
    .COST_WIDTH(COST_WIDTH_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of both stores and the registers
  logic [COST_IN_W-1:0]   cost_mem [DEPTH];
  logic [PHER_W-1:0]      pher_mem [DEPTH];
  bit                     cost_known [DEPTH];
  logic [NUM_NODES_W-1:0] node_reg  = NUM_NODES_RST;
  logic [PHER_W-1:0]      floor_reg = MIN_PHER_RST;

  pme_out_t due_results[$];
  dir_row_t dir_rows[$];
  int       mismatches   = 0;
  int       items_sent   = 0;
  int       sweeps       = 0;
  int       rejects      = 0;
  int       settings_run = 1;
  bit       idle_on      = 1'b1;

  function automatic int node_limit();
    return (node_reg > NODES) ? NODES : int'(node_reg);
  endfunction

  function automatic bit pair_valid(int s, int d);
    return (s != d) && (s < node_limit()) && (d < node_limit());
  endfunction

  function automatic logic [PHER_W-1:0] sat_sum(logic [PHER_W-1:0] a, logic [PHER_W-1:0] b);
    logic [PHER_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PHER_W] ? '1 : sum[PHER_W-1:0];
  endfunction

  // Expected result of one command; updates the shadow stores
  function automatic pme_out_t apply_command(pme_in_t it);
    pme_out_t         r;
    int               a;
    int               b;
    logic [COEF_W-1:0] c;
    logic [63:0]      prod;
    logic [PHER_W-1:0] p;
    r = '0;
    a = int'(it.src_node) * NODES + int'(it.dst_node);
    b = int'(it.dst_node) * NODES + int'(it.src_node);
    if (it.cmd <= CMD_DEPOSIT) begin
      if (!pair_valid(it.src_node, it.dst_node)) begin
        r.index_error = 1'b1;
      end else begin
        case (it.cmd)
          CMD_READ: begin
            r.cost_out = cost_mem[a];
            r.pher_out = pher_mem[a];
          end
          CMD_WRITE_COST: begin
            cost_mem[a]   = it.cost_in;
            cost_known[a] = 1'b1;
          end
          CMD_SET_PHER: begin
            pher_mem[a] = (it.pher_value > floor_reg) ? it.pher_value : floor_reg;
          end
          default: begin
            pher_mem[a] = sat_sum(pher_mem[a], it.pher_value);
            pher_mem[b] = sat_sum(pher_mem[b], it.pher_value);
          end
        endcase
      end
    end else if (it.cmd == CMD_EVAPORATE) begin
      c = (it.evap_coef > COEF_ONE) ? COEF_ONE : it.evap_coef;
      for (int i = 0; i < DEPTH; i++) begin
        prod = 64'(pher_mem[i]) * 64'(c);
        p = prod[PHER_W+15:16];
        pher_mem[i] = (p > floor_reg) ? p : floor_reg;
      end
    end else if (it.cmd == CMD_FILL) begin
      for (int i = 0; i < DEPTH; i++) pher_mem[i] = floor_reg;
    end
    return r;
  endfunction

  function automatic pme_in_t mk(logic [CMD_W-1:0] cmd, int s, int d, int cost,
                                 logic [PHER_W-1:0] pher, int coef);
    pme_in_t it;
    it.cmd        = cmd;
    it.src_node   = NODE_W'(s);
    it.dst_node   = NODE_W'(d);
    it.cost_in    = COST_IN_W'(cost);
    it.pher_value = pher;
    it.evap_coef  = COEF_W'(coef);
    return it;
  endfunction

  function automatic pme_out_t res(int cost, logic [PHER_W-1:0] pher, bit err);
    pme_out_t r;
    r.cost_out    = COST_IN_W'(cost);
    r.pher_out    = pher;
    r.index_error = err;
    return r;
  endfunction

  // Random command, biased toward valid pairs; never reads an unwritten cost
  function automatic pme_in_t random_command();
    pme_in_t it;
    int      n;
    int      pick;
    int      s;
    int      d;
    n    = node_limit();
    pick = $urandom_range(0, 99);
    it.cost_in = COST_IN_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       it.pher_value = $urandom;
      1:       it.pher_value = $urandom_range(0, 32'h3_FFFF);
      2:       it.pher_value = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
      default: it.pher_value = floor_reg + $urandom_range(0, 32'hFFFF) - 32'h8000;
    endcase
    it.evap_coef = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom_range(0, 32'h1_FFFF))
                                               : COEF_W'($urandom_range(32'hC000, 32'h1_0000));
    if (pick < 28)      it.cmd = CMD_READ;
    else if (pick < 48) it.cmd = CMD_WRITE_COST;
    else if (pick < 64) it.cmd = CMD_SET_PHER;
    else if (pick < 88) it.cmd = CMD_DEPOSIT;
    else if (pick < 90) it.cmd = CMD_EVAPORATE;
    else if (pick < 92) it.cmd = CMD_FILL;
    else if (pick < 95) it.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    else                it.cmd = CMD_W'($urandom_range(0, 3));
    if (n >= 2 && pick < 95 && $urandom_range(0, 9) != 0) begin
      s = $urandom_range(0, n - 1);
      d = $urandom_range(0, n - 2);
      if (d >= s) d++;
    end else begin
      s = $urandom_range(0, NODES - 1);
      d = $urandom_range(0, NODES - 1);
    end
    it.src_node = NODE_W'(s);
    it.dst_node = NODE_W'(d);
    if (it.cmd == CMD_READ && pair_valid(s, d) && !cost_known[s * NODES + d])
      it.cmd = CMD_WRITE_COST;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] error: %s", $time, msg);
  endtask

  // Present one item, wait for it to be taken, queue its expected result
  task automatic send_command(pme_in_t it, bit typed, pme_out_t want);
    int       gap;
    pme_out_t r;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    r = apply_command(it);
    due_results.push_back(typed ? want : r);
    items_sent++;
    if (it.cmd == CMD_EVAPORATE || it.cmd == CMD_FILL) sweeps++;
    if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
  endtask

  // Stop sending and wait for every queued result
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (due_results.size() != 0) begin
      report_mismatch("expected result never arrived");
      void'(due_results.pop_front());
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_NUM_NODES) node_reg = data[NUM_NODES_W-1:0];
    else                      floor_reg = data;
  endtask

  // Result checker
  always @(posedge clk) begin
    pme_out_t due;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        due = due_results.pop_front();
        if (out_data.cost_out !== due.cost_out)
          report_mismatch($sformatf("cost_out %h, want %h", out_data.cost_out, due.cost_out));
        if (out_data.pher_out !== due.pher_out)
          report_mismatch($sformatf("pher_out %h, want %h", out_data.pher_out, due.pher_out));
        if (out_data.index_error !== due.index_error)
          report_mismatch($sformatf("index_error %b, want %b", out_data.index_error,
                                    due.index_error));
        if (due.index_error) rejects++;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned ph_nodes [6];
    logic [31:0] ph_floor [6];
    int          ph_items [6];
    ph_nodes = '{8, 127, 2, 0, 64, 0};
    ph_floor = '{32'h0000_8000, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0};
    ph_items = '{200, 200, 80, 30, 240, 80};
    ph_floor[3] = $urandom;
    ph_nodes[5] = $urandom_range(2, 127);
    ph_floor[5] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill first so every pheromone is defined before use
    dir_rows.push_back('{mk(CMD_FILL, 0, 0, 0, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 5, 5, 0, 0, 0), 1, res(0, 0, 1)});
    dir_rows.push_back('{mk(CMD_SPARE_A, 0, 1, 0, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_WRITE_COST, 0, 63, 16'hFFFF, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 0, 63, 0, 0, 0), 1, res(16'hFFFF, 32'h1_0000, 0)});
    dir_rows.push_back('{mk(CMD_WRITE_COST, 63, 0, 0, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 63, 0, 0, 0, 0), 1, res(0, 32'h1_0000, 0)});
    // set below the floor is clamped up
    dir_rows.push_back('{mk(CMD_SET_PHER, 0, 63, 0, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 0, 63, 0, 0, 0), 1, res(16'hFFFF, 32'h1_0000, 0)});
    dir_rows.push_back('{mk(CMD_SET_PHER, 0, 63, 0, 32'hFFFF_FFFF, 0), 1, res(0, 0, 0)});
    // deposit saturates on one direction only
    dir_rows.push_back('{mk(CMD_DEPOSIT, 0, 63, 0, 32'h1234_5678, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 0, 63, 0, 0, 0), 1, res(16'hFFFF, 32'hFFFF_FFFF, 0)});
    dir_rows.push_back('{mk(CMD_READ, 63, 0, 0, 0, 0), 0, '0});
    // coefficient of one, and one above one that saturates
    dir_rows.push_back('{mk(CMD_EVAPORATE, 0, 0, 0, 0, 32'h1_0000), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_EVAPORATE, 63, 63, 0, 0, 32'h1_FFFF), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 0, 63, 0, 0, 0), 1, res(16'hFFFF, 32'hFFFF_FFFF, 0)});
    dir_rows.push_back('{mk(CMD_EVAPORATE, 0, 0, 0, 0, 32'h8000), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 0, 63, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(CMD_READ, 63, 0, 0, 0, 0), 0, '0});
    // coefficient of zero drops everything to the floor
    dir_rows.push_back('{mk(CMD_EVAPORATE, 0, 0, 0, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_READ, 0, 63, 0, 0, 0), 1, res(16'hFFFF, 32'h1_0000, 0)});
    dir_rows.push_back('{mk(CMD_WRITE_COST, 1, 2, 16'h1234, 0, 0), 1, res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_SPARE_B, 63, 63, 16'hFFFF, 32'hFFFF_FFFF, 32'h1_FFFF), 1,
                         res(0, 0, 0)});
    dir_rows.push_back('{mk(CMD_SET_PHER, 7, 7, 0, 32'h5_0000, 0), 1, res(0, 0, 1)});
    dir_rows.push_back('{mk(CMD_DEPOSIT, 63, 63, 0, 32'h5_0000, 0), 1, res(0, 0, 1)});
    dir_rows.push_back('{mk(CMD_READ, 1, 2, 0, 0, 0), 0, '0});
    foreach (dir_rows[i]) send_command(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    settle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_NUM_NODES, ($urandom & 32'hFFFF_FF80) | ph_nodes[ph]);
      write_reg(REG_MIN_PHER, ph_floor[ph]);
      settings_run++;
      for (int k = 0; k < ph_items[ph]; k++) send_command(random_command(), 1'b0, '0);
      settle();
    end

    $display("Sent %0d items over %0d register settings", items_sent, settings_run);
    $display("  %0d full-store sweeps, %0d rejected node pairs", sweeps, rejects);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
